// ----- src/binary_to_decimal_ascii_top_defines.svh -----
// Assertion macros for the binary to decimal ASCII converter.
`ifndef BINARY_TO_DECIMAL_ASCII_TOP_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_TOP_DEFINES_SVH

// Check that a condition implies a consequence in the same cycle.
`define B2DA_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define B2DA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- src/b2da_pkg.sv -----
// Shared types and constants for the binary to decimal ASCII converter.
package b2da_pkg;

   localparam int VALUE_WIDTH_DEFAULT = 64;
   localparam int DIGIT_WIDTH         = 4;
   localparam int CHAR_WIDTH          = 6;

   localparam logic [CHAR_WIDTH-1:0]  ASCII_ZERO = 6'd48;
   localparam logic [DIGIT_WIDTH-1:0] DABBLE_MIN = 4'd5;
   localparam logic [DIGIT_WIDTH-1:0] DABBLE_ADD = 4'd3;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic clear;
      logic dabble;
      logic move;
   } cell_ctrl_type;

endpackage

// ----- src/b2da_channels.sv -----
// Valid/ready channel interfaces for request and response items.
interface b2da_req_if #(
   parameter int VALUE_WIDTH = b2da_pkg::VALUE_WIDTH_DEFAULT
);
   logic                   valid;
   logic                   ready;
   logic [VALUE_WIDTH-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface b2da_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [b2da_pkg::CHAR_WIDTH-1:0] digit_char;
   logic                            last_digit;

   modport source (output valid, output digit_char, output last_digit, input ready);
   modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

// ----- src/binary_to_decimal_ascii_top.sv -----
// Top level: binary value in, decimal ASCII digits out, one digit per item.
// Steps: accept in idle, shift every value bit through the BCD cell chain,
// then move the digits to the output one slot at a time, skipping leading zeros.
// A new value is taken only once the last digit has gone to the output register,
// and emission waits while the response side stalls.
// Reset: synchronous, active high; clears control state, cell digits need none.
`include "binary_to_decimal_ascii_top_defines.svh"

module binary_to_decimal_ascii_top #(
   parameter int VALUE_WIDTH = b2da_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   b2da_req_if.sink          req_ch,
   b2da_rsp_if.source        rsp_ch
);

   localparam int NUM_DIGITS = (VALUE_WIDTH * 77) / 256 + 1;
   localparam int BIT_CNT_W  = $clog2(VALUE_WIDTH + 1);
   localparam int REM_CNT_W  = $clog2(NUM_DIGITS + 1);

   b2da_pkg::state_type state_ff, state_in;

   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic [BIT_CNT_W-1:0]   bit_cnt_ff, bit_cnt_in;
   logic [REM_CNT_W-1:0]   remain_ff, remain_in;
   logic                   seen_ff, seen_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [b2da_pkg::CHAR_WIDTH-1:0] char_ff, char_in;
   logic                   last_ff, last_in;

   b2da_pkg::cell_ctrl_type ctrl;
   logic                    accept;
   logic                    out_free;
   logic                    skip;
   logic                    step;
   logic                    load;

   logic [NUM_DIGITS:0]                carry;
   logic [b2da_pkg::DIGIT_WIDTH-1:0]   digits [NUM_DIGITS];
   logic [b2da_pkg::DIGIT_WIDTH-1:0]   top_digit;

   assign carry[0]  = value_ff[VALUE_WIDTH-1];
   assign top_digit = digits[NUM_DIGITS-1];

   for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
      logic [b2da_pkg::DIGIT_WIDTH-1:0] lower;
      if (i == 0) begin : g_first
         assign lower = '0;
      end else begin : g_rest
         assign lower = digits[i-1];
      end
      b2da_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .bit_in    (carry[i]),
         .digit_in  (lower),
         .bit_out   (carry[i+1]),
         .digit_out (digits[i])
      );
   end

   assign accept   = req_ch.valid && req_ch.ready;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign skip     = (top_digit == '0) && !seen_ff && (remain_ff > REM_CNT_W'(1));

   // control outputs
   always_comb begin
      req_ch.ready = 1'b0;
      ctrl         = '0;
      step         = 1'b0;
      load         = 1'b0;
      unique case (state_ff)
         b2da_pkg::ST_IDLE: begin
            req_ch.ready = 1'b1;
            ctrl.clear   = 1'b1;
         end
         b2da_pkg::ST_CONVERT: begin
            ctrl.dabble = 1'b1;
         end
         b2da_pkg::ST_EMIT: begin
            step      = skip || out_free;
            load      = out_free && !skip;
            ctrl.move = step;
         end
         default: begin
            req_ch.ready = 1'b0;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         b2da_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = b2da_pkg::ST_CONVERT;
            end
         end
         b2da_pkg::ST_CONVERT: begin
            if (bit_cnt_ff == BIT_CNT_W'(1)) begin
               state_in = b2da_pkg::ST_EMIT;
            end
         end
         b2da_pkg::ST_EMIT: begin
            if (load && remain_ff == REM_CNT_W'(1)) begin
               state_in = b2da_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = b2da_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath registers
   always_comb begin
      value_in   = value_ff;
      bit_cnt_in = bit_cnt_ff;
      remain_in  = remain_ff;
      seen_in    = seen_ff;
      if (accept) begin
         value_in   = req_ch.value;
         bit_cnt_in = BIT_CNT_W'(VALUE_WIDTH);
      end else if (state_ff == b2da_pkg::ST_CONVERT) begin
         value_in   = {value_ff[VALUE_WIDTH-2:0], 1'b0};
         bit_cnt_in = bit_cnt_ff - BIT_CNT_W'(1);
         remain_in  = REM_CNT_W'(NUM_DIGITS);
         seen_in    = 1'b0;
      end else if (step) begin
         remain_in = remain_ff - REM_CNT_W'(1);
         seen_in   = seen_ff || load;
      end
   end

   always_comb begin
      char_in = char_ff;
      last_in = last_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
         char_in      = b2da_pkg::ASCII_ZERO + b2da_pkg::CHAR_WIDTH'(top_digit);
         last_in      = (remain_ff == REM_CNT_W'(1));
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= b2da_pkg::ST_IDLE;
         bit_cnt_ff   <= '0;
         remain_ff    <= '0;
         seen_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bit_cnt_ff   <= bit_cnt_in;
         remain_ff    <= remain_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      char_ff  <= char_in;
      last_ff  <= last_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.digit_char = char_ff;
   assign rsp_ch.last_digit = last_ff;

   `B2DA_ASSERT_NEXT(a_accept_starts, accept, state_ff == b2da_pkg::ST_CONVERT, "accepted item did not start conversion")
   `B2DA_ASSERT_SAME(a_no_overflow, state_ff == b2da_pkg::ST_CONVERT, !carry[NUM_DIGITS], "carry left the top BCD cell")
   `B2DA_ASSERT_SAME(a_digit_range, state_ff == b2da_pkg::ST_EMIT, top_digit <= 4'd9, "top cell holds a non-decimal digit")
   `B2DA_ASSERT_SAME(a_remain_live, state_ff == b2da_pkg::ST_EMIT, remain_ff != '0, "emit phase ran past the last digit")

endmodule

// ----- src/b2da_cell.sv -----
// One BCD digit cell of the double dabble chain.
module b2da_cell (
   input  logic                               clock,
   input  b2da_pkg::cell_ctrl_type            ctrl,
   input  logic                               bit_in,
   input  logic [b2da_pkg::DIGIT_WIDTH-1:0]   digit_in,
   output logic                               bit_out,
   output logic [b2da_pkg::DIGIT_WIDTH-1:0]   digit_out
);

   logic [b2da_pkg::DIGIT_WIDTH-1:0] digit_ff;
   logic [b2da_pkg::DIGIT_WIDTH-1:0] digit_in_next;
   logic [b2da_pkg::DIGIT_WIDTH-1:0] adj;

   assign adj = (digit_ff >= b2da_pkg::DABBLE_MIN) ? (digit_ff + b2da_pkg::DABBLE_ADD)
                                                   : digit_ff;
   assign bit_out   = adj[b2da_pkg::DIGIT_WIDTH-1];
   assign digit_out = digit_ff;

   always_comb begin
      if (ctrl.clear) begin
         digit_in_next = '0;
      end else if (ctrl.dabble) begin
         digit_in_next = {adj[b2da_pkg::DIGIT_WIDTH-2:0], bit_in};
      end else if (ctrl.move) begin
         digit_in_next = digit_in;
      end else begin
         digit_in_next = digit_ff;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in_next;
   end

endmodule
